### rtl/core/scs_pkg.sv
// Shared types and constants for the sparse challenge sampler.
// No dependencies; used by scs_taken_store and sparse_challenge_sampler.
`default_nettype none

package scs_pkg;

  // Default sizes of the sampled vector.
  localparam int DEF_VECTOR_LEN = 512;
  localparam int DEF_POS_BITS   = 9;
  localparam int DEF_WEIGHT     = 19;

  // Fixed widths of the result fields.
  localparam int POSITION_W = 9;
  localparam int INDEX_W    = 5;

  // Challenge number kept beside each position in the taken store.
  localparam int EPOCH_W = 8;
  typedef logic [EPOCH_W-1:0] epoch_t;
  localparam epoch_t EPOCH_FIRST = epoch_t'(1);
  localparam epoch_t EPOCH_LAST  = '1;

  // Commands from the parser to the taken store.
  typedef struct packed {
    logic lookup;     // read the tag of a candidate position
    logic mark;       // mark the pending position as taken
    logic advance;    // a new challenge begins
    logic sweep_req;  // the challenge number is exhausted, clear the store
  } scs_ctrl_t;

  // Status from the taken store to the parser.
  typedef struct packed {
    logic busy;       // clearing pass in progress
    logic wrap_due;   // the next challenge needs a clearing pass first
    logic hit;        // the looked-up position is taken in this challenge
  } scs_status_t;

  // One result item.
  typedef struct packed {
    logic [POSITION_W-1:0] position;
    logic                  negative;
    logic [INDEX_W-1:0]    entry_index;
    logic                  last;
  } scs_result_t;

endpackage

`default_nettype wire

### rtl/core/sparse_challenge_sampler.sv
// Sparse ternary challenge sampler: parses keystream bytes into signed positions.
// Depends on scs_pkg and scs_taken_store.
`default_nettype none

//  Channel   Signals                                         Direction
//  byte      byte_valid, byte_stall, stream_byte, start_req  in (stall out)
//  result    result_valid, result_stall, position, negative,
//            entry_index, last                               out (stall in)
//
// One byte is accepted per cycle while byte_stall is low; a sign byte's result item is
// registered in the output stage. The taken check is one read of the tag memory, issued
// with the low byte and used with the byte that follows it. After reset a clearing pass
// holds byte_stall high; a start that would exhaust the 8-bit challenge number holds its
// byte while it requests a clearing pass and while the pass itself runs.
// A two-entry output stage keeps bytes flowing while one result waits.

module sparse_challenge_sampler #(
  parameter int VECTOR_LEN = scs_pkg::DEF_VECTOR_LEN,
  parameter int POS_BITS   = scs_pkg::DEF_POS_BITS,
  parameter int WEIGHT     = scs_pkg::DEF_WEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_valid,
  output logic                         byte_stall,
  input  logic [7:0]                   stream_byte,
  input  logic                         start_req,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [scs_pkg::POSITION_W-1:0] position,
  output logic                         negative,
  output logic [scs_pkg::INDEX_W-1:0]  entry_index,
  output logic                         last
);
  import scs_pkg::*;

  localparam int ADDR_W  = $clog2(VECTOR_LEN);
  localparam int LEN_W   = $clog2(VECTOR_LEN + 1);
  localparam int CMP_W   = (POS_BITS > LEN_W) ? POS_BITS : LEN_W;
  localparam int FOUND_W = $clog2(WEIGHT + 1);
  localparam logic [CMP_W-1:0]   LEN_LIMIT  = CMP_W'(VECTOR_LEN);
  localparam logic [FOUND_W-1:0] FOUND_LAST = FOUND_W'(WEIGHT - 1);

  typedef enum logic [1:0] {
    PH_HIGH,
    PH_LOW,
    PH_DECIDE
  } phase_t;

  // Parser state.
  phase_t              phase, phase_next, cur_phase;
  logic [7:0]          high_byte, high_byte_next;
  logic [POS_BITS-1:0] cand, cand_next, cand_in;
  logic                cand_ok, cand_ok_next;
  logic [FOUND_W-1:0]  found, found_next, cur_found;
  logic                finished, finished_next, cur_finished;

  // Output stage.
  scs_result_t out_res, skid_res, res;
  logic        skid_valid;
  logic        emit;

  // Handshake and store interface.
  logic               accept, take, wrap_block;
  logic [15:0]        word;
  logic [CMP_W-1:0]   cand_in_wide, cand_wide;
  logic               in_range;
  scs_ctrl_t          ctrl;
  scs_status_t        status;

  scs_taken_store #(
    .VECTOR_LEN(VECTOR_LEN)
  ) u_taken (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .lookup_addr(cand_in_wide[ADDR_W-1:0]),
    .mark_addr  (cand_wide[ADDR_W-1:0]),
    .status     (status)
  );

  // Handshakes. A start that needs a clearing pass waits for it.
  assign wrap_block = byte_valid && start_req && status.wrap_due;
  assign byte_stall = status.busy || wrap_block || skid_valid;
  assign accept     = byte_valid && !byte_stall;
  assign take       = result_valid && !result_stall;

  // Candidate position from the stored high byte and the current byte.
  assign word         = {high_byte, stream_byte};
  assign cand_in      = word[POS_BITS-1:0];
  assign cand_in_wide = CMP_W'(cand_in);
  assign cand_wide    = CMP_W'(cand);
  assign in_range     = (cand_in_wide < LEN_LIMIT);

  // Result fields for a sign byte.
  assign res.position    = POSITION_W'(cand);
  assign res.negative    = stream_byte[0];
  assign res.entry_index = INDEX_W'(found);
  assign res.last        = (found == FOUND_LAST);

  // Next-state logic for one accepted byte.
  always_comb begin
    cur_phase      = start_req ? PH_HIGH : phase;
    cur_found      = start_req ? '0 : found;
    cur_finished   = start_req ? 1'b0 : finished;
    phase_next     = phase;
    high_byte_next = high_byte;
    cand_next      = cand;
    cand_ok_next   = cand_ok;
    found_next     = found;
    finished_next  = finished;
    emit           = 1'b0;
    ctrl           = '0;
    ctrl.sweep_req = wrap_block && !status.busy;
    if (accept) begin
      ctrl.advance  = start_req;
      phase_next    = cur_phase;
      found_next    = cur_found;
      finished_next = cur_finished;
      if (!cur_finished) begin
        case (cur_phase)
          PH_HIGH: begin
            high_byte_next = stream_byte;
            phase_next     = PH_LOW;
          end
          PH_LOW: begin
            ctrl.lookup  = 1'b1;
            cand_next    = cand_in;
            cand_ok_next = in_range;
            phase_next   = PH_DECIDE;
          end
          PH_DECIDE: begin
            if (cand_ok && !status.hit) begin
              // Accepted candidate: this byte carries the sign.
              emit          = 1'b1;
              ctrl.mark     = 1'b1;
              found_next    = found + 1'b1;
              finished_next = (found == FOUND_LAST);
              phase_next    = PH_HIGH;
            end else begin
              // Rejected candidate: this byte opens the next one.
              high_byte_next = stream_byte;
              phase_next     = PH_LOW;
            end
          end
          default: begin
            phase_next = PH_HIGH;
          end
        endcase
      end
    end
  end

  // State and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HIGH;
      found        <= '0;
      finished     <= 1'b0;
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      phase    <= phase_next;
      found    <= found_next;
      finished <= finished_next;
      if (skid_valid) begin
        if (take) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end
      end else if (emit) begin
        if (!result_valid || take) begin
          out_res      <= res;
          result_valid <= 1'b1;
        end else begin
          skid_res   <= res;
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        result_valid <= 1'b0;
      end
    end
    high_byte <= high_byte_next;
    cand      <= cand_next;
    cand_ok   <= cand_ok_next;
  end

  assign position    = out_res.position;
  assign negative    = out_res.negative;
  assign entry_index = out_res.entry_index;
  assign last        = out_res.last;

endmodule

`default_nettype wire

### rtl/core/scs_taken_store.sv
// Taken-position store: one challenge tag per vector position, with a clearing pass.
// Depends on scs_pkg.
`default_nettype none

module scs_taken_store #(
  parameter int VECTOR_LEN = scs_pkg::DEF_VECTOR_LEN,
  localparam int ADDR_W = $clog2(VECTOR_LEN)
) (
  input  logic                clk,
  input  logic                rst,
  input  scs_pkg::scs_ctrl_t  ctrl,
  input  logic [ADDR_W-1:0]   lookup_addr,
  input  logic [ADDR_W-1:0]   mark_addr,
  output scs_pkg::scs_status_t status
);
  import scs_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VECTOR_LEN - 1);

  epoch_t            tag_mem [VECTOR_LEN];
  epoch_t            rd_tag;
  epoch_t            epoch;
  logic              sweeping;
  logic [ADDR_W-1:0] sweep_addr;

  // Challenge number and clearing pass. Tags of zero never match a live challenge.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      epoch      <= EPOCH_FIRST;
    end else if (sweeping) begin
      if (sweep_addr == LAST_ADDR) begin
        sweeping <= 1'b0;
        epoch    <= EPOCH_FIRST;
      end else begin
        sweep_addr <= sweep_addr + 1'b1;
      end
    end else if (ctrl.sweep_req) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (ctrl.advance) begin
      epoch <= epoch + 1'b1;
    end
  end

  // Tag memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (sweeping) begin
      tag_mem[sweep_addr] <= '0;
    end else if (ctrl.mark) begin
      tag_mem[mark_addr] <= epoch;
    end
    if (ctrl.lookup) begin
      rd_tag <= tag_mem[lookup_addr];
    end
  end

  // A position is taken when its tag carries the current challenge number.
  assign status.busy     = sweeping;
  assign status.wrap_due = (epoch == EPOCH_LAST);
  assign status.hit      = (rd_tag == epoch);

endmodule

`default_nettype wire
